### src/pdfc_pkg.sv
// Package: shared widths, register indexes and types for the PD force controller.
`timescale 1ns / 1ps
package pdfc_pkg;
  localparam int unsigned PosW  = 32;
  localparam int unsigned ErrW  = 40;
  localparam int unsigned GainW = 24;
  localparam int unsigned DivW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegPropGain  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDerivGain = 2'd1;
  localparam logic [CfgIdxW-1:0] RegApproach  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegLimit     = 2'd3;

  typedef struct packed {
    logic signed [PosW-1:0] master_x;
    logic signed [PosW-1:0] master_y;
    logic signed [PosW-1:0] master_z;
    logic signed [PosW-1:0] slave_x;
    logic signed [PosW-1:0] slave_y;
    logic signed [PosW-1:0] slave_z;
  } pos_req_t;

  typedef struct packed {
    logic signed [PosW-1:0] force_x;
    logic signed [PosW-1:0] force_y;
    logic signed [PosW-1:0] force_z;
    logic                   limited;
  } force_rsp_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_req_t;
endpackage

### src/pdfc_if.sv
// Interfaces: valid/ready request channels for positions, forces and configuration.
`timescale 1ns / 1ps
interface pdfc_pos_if;
  logic valid;
  logic ready;
  pdfc_pkg::pos_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pdfc_force_if;
  logic valid;
  logic ready;
  pdfc_pkg::force_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pdfc_cfg_if;
  logic valid;
  logic ready;
  pdfc_pkg::cfg_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/pdfc_divu.sv
// Bit-serial unsigned restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module pdfc_divu #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW:0]   trial;
  logic [DenW:0]   shifted;

  always_comb begin
    quot_d  = quot_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    shifted = {rem_q[DenW-1:0], quot_q[NumW-1]};
    trial   = shifted - {1'b0, den_q};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
    end else if (cnt_q != '0) begin
      // shift in one numerator bit, subtract when it fits
      if (!trial[DenW]) begin
        rem_d  = trial;
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;
endmodule

### src/pdfc_sqrt.sv
// Serial integer square root: two radicand bits per cycle, one root bit out.
`timescale 1ns / 1ps
module pdfc_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        busy_o,
  output logic [31:0] root_o
);
  logic [63:0] rad_q, rad_d;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [33:0] cur;
  logic [33:0] trial;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    cur    = {rem_q[31:0], rad_q[63:62]};
    trial  = cur - {root_q, 2'b01};
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = 6'd32;
    end else if (cnt_q != '0) begin
      rad_d = {rad_q[61:0], 2'b00};
      if (!trial[33]) begin
        rem_d  = trial;
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = cur;
        root_d = {root_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = (cnt_q != '0);
  assign root_o = root_q;
endmodule

### src/pdfc_mul.sv
// Shift-add multiplier: signed 48-bit multiplicand times unsigned 24-bit, one bit a cycle.
`timescale 1ns / 1ps
module pdfc_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [47:0] a_i,
  input  logic [23:0]        b_i,
  output logic               busy_o,
  output logic signed [71:0] prod_o
);
  logic signed [71:0] acc_q, acc_d;
  logic signed [71:0] a_q, a_d;
  logic [23:0]        b_q, b_d;
  logic [4:0]         cnt_q, cnt_d;

  always_comb begin
    acc_d = acc_q;
    a_d   = a_q;
    b_d   = b_q;
    cnt_d = cnt_q;
    if (start_i) begin
      acc_d = '0;
      a_d   = 72'(a_i);
      b_d   = b_i;
      cnt_d = 5'd24;
    end else if (cnt_q != '0) begin
      // add the shifted multiplicand where the multiplier bit is set
      if (b_q[0]) acc_d = acc_q + a_q;
      a_d   = a_q <<< 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign busy_o = (cnt_q != '0);
  assign prod_o = acc_q;
endmodule

### src/pd_force_controller_3axis.sv
// Top level: three-axis PD force controller with Euclidean force limit.
// Each request passes through the bit-serial units: per axis a divide and two
//   multiplies, then scaling shifts, and when the force is limited a square
//   root and three divides.
// Throughput: one request at a time; the next request is taken once the
//   result has moved to the output register. Reset: registers return to their
//   documented values, previous errors clear.
`timescale 1ns / 1ps
module pd_force_controller_3axis (
  input  logic clk_i,
  input  logic rst_ni,
  pdfc_cfg_if.sink     cfg,
  pdfc_pos_if.sink     pos,
  pdfc_force_if.source frc
);
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StDiv   = 4'd1;
  localparam logic [3:0] StDivW  = 4'd2;
  localparam logic [3:0] StMulP  = 4'd3;
  localparam logic [3:0] StMulPW = 4'd4;
  localparam logic [3:0] StMulD  = 4'd5;
  localparam logic [3:0] StMulDW = 4'd6;
  localparam logic [3:0] StAxis  = 4'd7;
  localparam logic [3:0] StLim   = 4'd8;
  localparam logic [3:0] StSqrt  = 4'd9;
  localparam logic [3:0] StSqrtW = 4'd10;
  localparam logic [3:0] StNorm  = 4'd11;
  localparam logic [3:0] StNormW = 4'd12;
  localparam logic [3:0] StOut   = 4'd13;
  localparam logic [3:0] StShift = 4'd14;

  // Configuration registers
  logic [23:0] prop_gain_q, deriv_gain_q, force_limit_q;
  logic [15:0] approach_div_q;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q    <= 24'd58982;
      deriv_gain_q   <= 24'd98304;
      approach_div_q <= 16'd10000;
      force_limit_q  <= 24'd157286;
    end else if (cfg.valid) begin
      unique case (cfg.data.idx)
        pdfc_pkg::RegPropGain:  prop_gain_q    <= cfg.data.data[23:0];
        pdfc_pkg::RegDerivGain: deriv_gain_q   <= cfg.data.data[23:0];
        pdfc_pkg::RegApproach:  approach_div_q <= cfg.data.data[15:0];
        pdfc_pkg::RegLimit:     force_limit_q  <= cfg.data.data[23:0];
        default: ;
      endcase
    end
  end

  logic [3:0] st_q, st_d;
  logic [1:0] ax_q, ax_d;
  logic signed [31:0] m_q [3];
  logic signed [31:0] s_q [3];
  logic signed [39:0] prev_q [3];
  logic signed [39:0] err_q;
  logic signed [39:0] dlt_q;
  logic signed [47:0] t1_q;
  logic signed [40:0] fsum_q [3];   // t1 + t2, force is that times 100
  logic signed [47:0] frc_q [3];
  logic [47:0] mag_q [3];
  logic        lim_q;
  logic [31:0] root_q;
  logic        out_valid_q;
  pdfc_pkg::force_rsp_t out_q;

  // Divider shared by error and normalization
  logic div_start, div_busy;
  logic [47:0] div_num;
  logic [31:0] div_den;
  logic [47:0] div_quot;
  pdfc_divu #(.NumW(48), .DenW(32)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quot_o(div_quot)
  );

  logic mul_start, mul_busy;
  logic signed [47:0] mul_a;
  logic [23:0] mul_b;
  logic signed [71:0] mul_p;
  pdfc_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .busy_o(mul_busy), .prod_o(mul_p)
  );

  logic sq_start, sq_busy;
  logic [63:0] sq_rad;
  logic [31:0] sq_root;
  pdfc_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .rad_i(sq_rad), .busy_o(sq_busy), .root_o(sq_root)
  );

  // Per-axis operands
  logic signed [32:0] diff;
  logic [40:0]        diff_mag;
  logic               diff_neg;
  logic [15:0]        div_eff;
  logic signed [48:0] err_raw;
  logic signed [40:0] dlt_raw;
  logic signed [47:0] prod_sh;
  logic signed [47:0] axis_f;
  logic [29:0]        sv;
  logic [63:0]        sumsq;

  assign diff     = 33'(m_q[ax_q]) - 33'(s_q[ax_q]);
  assign diff_neg = diff[32];
  assign diff_mag = diff_neg ? 41'(-(41'(diff))) << 8 : 41'(diff) << 8;
  assign div_eff  = (approach_div_q == '0) ? 16'd1 : approach_div_q;
  assign err_raw  = diff_neg ? -49'(div_quot) : 49'(div_quot);
  assign dlt_raw  = 41'(err_q) - 41'(prev_q[ax_q]);
  assign prod_sh  = 48'(mul_p >>> 24);
  assign axis_f   = 48'(fsum_q[ax_q]) * 48'sd100;
  assign sv       = mag_q[ax_q][29:0];
  // each term is below 2^60, three of them fit 64 bits
  assign sumsq    = 64'(sv) * 64'(sv);

  logic [63:0] sum_q;
  logic        any_big;
  assign any_big = (mag_q[0][47:30] != '0) || (mag_q[1][47:30] != '0) ||
                   (mag_q[2][47:30] != '0);

  // Sum-of-squares limit test. When no component exceeds the limit every
  // component is below 2^24, nothing is shifted and the serial sum is exact.
  logic [47:0] lim_sq;
  logic        sq_over;
  assign lim_sq  = 48'(force_limit_q) * 48'(force_limit_q);
  assign sq_over = ((sum_q + sumsq) > 64'(lim_sq));

  always_comb begin
    div_start = 1'b0;
    div_num = 48'(diff_mag);
    div_den = 32'(div_eff);
    mul_start = 1'b0;
    mul_a = 48'(err_q);
    mul_b = prop_gain_q;
    sq_start = 1'b0;
    sq_rad = sum_q;
    st_d = st_q;
    ax_d = ax_q;
    if (st_q == StNorm || st_q == StNormW) begin
      div_num = {2'b00, sv, 16'h0000};
      div_den = root_q;
    end
    if (st_q == StMulD) begin
      mul_a = 48'(dlt_q);
      mul_b = deriv_gain_q;
    end
    unique case (st_q)
      StIdle:  if (pos.valid) begin st_d = StDiv; ax_d = 2'd0; end
      StDiv:   begin div_start = 1'b1; st_d = StDivW; end
      StDivW:  if (!div_busy) st_d = StMulP;
      StMulP:  begin mul_start = 1'b1; st_d = StMulPW; end
      StMulPW: if (!mul_busy) st_d = StMulD;
      StMulD:  begin mul_start = 1'b1; st_d = StMulDW; end
      StMulDW: if (!mul_busy) st_d = StAxis;
      StAxis:  begin
        if (ax_q == 2'd2) begin st_d = StLim; ax_d = 2'd0; end
        else begin st_d = StDiv; ax_d = ax_q + 2'd1; end
      end
      StLim:   st_d = StShift;
      StShift: begin
        // scale down first, then sum the squares one axis a cycle
        if (!any_big && ax_q == 2'd2) begin
          st_d = (lim_q || sq_over) ? StSqrt : StOut;
          ax_d = 2'd0;
        end else if (!any_big) ax_d = ax_q + 2'd1;
      end
      StSqrt:  begin sq_start = 1'b1; st_d = StSqrtW; end
      StSqrtW: if (!sq_busy) begin st_d = StNorm; ax_d = 2'd0; end
      StNorm:  begin div_start = (root_q != '0); st_d = StNormW; end
      StNormW: if (!div_busy) begin
        if (ax_q == 2'd2) st_d = StOut;
        else begin st_d = StNorm; ax_d = ax_q + 2'd1; end
      end
      StOut:   if (!out_valid_q || frc.ready) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  assign pos.ready = (st_q == StIdle);

  logic signed [39:0] err_sat;
  logic signed [39:0] dlt_sat;
  assign err_sat = (err_raw > 49'sd549755813887) ? 40'sh7FFFFFFFFF :
                   (err_raw < -49'sd549755813888) ? 40'sh8000000000 : 40'(err_raw);
  assign dlt_sat = (dlt_raw > 41'sd549755813887) ? 40'sh7FFFFFFFFF :
                   (dlt_raw < -41'sd549755813888) ? 40'sh8000000000 : 40'(dlt_raw);

  logic [47:0] lim48;
  assign lim48 = 48'(force_limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ax_q <= '0;
      prev_q[0] <= '0;
      prev_q[1] <= '0;
      prev_q[2] <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ax_q <= ax_d;
      if (st_q == StMulP) prev_q[ax_q] <= err_q;  // hold error for next tick
      if (frc.ready) out_valid_q <= 1'b0;
      if (st_q == StOut && (!out_valid_q || frc.ready)) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: if (pos.valid) begin
        m_q[0] <= pos.data.master_x; m_q[1] <= pos.data.master_y;
        m_q[2] <= pos.data.master_z;
        s_q[0] <= pos.data.slave_x;  s_q[1] <= pos.data.slave_y;
        s_q[2] <= pos.data.slave_z;
        lim_q <= 1'b0;
        sum_q <= '0;
      end
      StDivW: if (!div_busy) err_q <= err_sat;
      StMulP: dlt_q <= dlt_sat;
      StMulPW: if (!mul_busy) t1_q <= prod_sh;
      StMulDW: if (!mul_busy) fsum_q[ax_q] <= 41'(t1_q) + 41'(prod_sh);
      StAxis: begin
        frc_q[ax_q] <= axis_f;
        mag_q[ax_q] <= axis_f[47] ? 48'(-axis_f) : 48'(axis_f);
      end
      StLim: begin
        // any component above the limit
        if (mag_q[0] > lim48 || mag_q[1] > lim48 || mag_q[2] > lim48) lim_q <= 1'b1;
      end
      StShift: begin
        if (any_big) begin
          mag_q[0] <= mag_q[0] >> 1; mag_q[1] <= mag_q[1] >> 1;
          mag_q[2] <= mag_q[2] >> 1;
        end else begin
          sum_q <= sum_q + sumsq;
          if (ax_q == 2'd2 && sq_over) lim_q <= 1'b1;
        end
      end
      StSqrtW: if (!sq_busy) root_q <= sq_root;
      StNormW: if (!div_busy) begin
        frc_q[ax_q] <= (root_q == '0) ? 48'sd0 :
                       (frc_q[ax_q][47] ? -48'(div_quot) : 48'(div_quot));
      end
      StOut: if (!out_valid_q || frc.ready) begin
        out_q.force_x <= frc_q[0][31:0];
        out_q.force_y <= frc_q[1][31:0];
        out_q.force_z <= frc_q[2][31:0];
        out_q.limited <= lim_q;
      end
      default: ;
    endcase
  end

  assign frc.valid = out_valid_q;
  assign frc.data  = out_q;
endmodule

### src/pdfc_checker.sv
// Checker: port-level properties of the PD force controller, bound to the top level.
`timescale 1ns / 1ps
module pdfc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic [31:0] force_x_i,
  input logic limited_i
);
  // a result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(force_x_i) && $stable(limited_i))
    else $error("result dropped or changed while stalled");
  // no request taken in the cycle after one was taken
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while busy");
  // results appear only some time after a request
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result without work");
endmodule

bind pd_force_controller_3axis pdfc_checker u_pdfc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(pos.valid), .in_ready_i(pos.ready),
  .out_valid_i(frc.valid), .out_ready_i(frc.ready), .force_x_i(frc.data.force_x),
  .limited_i(frc.data.limited)
);

### bench/testbench.sv
// Testbench for the three-axis PD force controller: random and directed ticks, scoreboard check.
`timescale 1ns / 1ps
module testbench;
  localparam longint ErrMax = 64'sd549755813887;
  localparam longint ErrMin = -64'sd549755813888;
  localparam int unsigned CycleLimit = 12_000_000;
  localparam int unsigned DrainCycles = 700;

  // Track controller state and the queue of forces still owed by the block.
  class force_scoreboard;
    longint prop_gain, deriv_gain, divisor, force_limit;
    longint prev_err[3];
    pdfc_pkg::force_rsp_t owed_forces[$];
    int unsigned errors;

    function new();
      prop_gain = 58982;
      deriv_gain = 98304;
      divisor = 10000;
      force_limit = 157286;
      prev_err = '{0, 0, 0};
      errors = 0;
    endfunction

    function void set_reg(logic [pdfc_pkg::CfgIdxW-1:0] idx,
                          logic [pdfc_pkg::CfgDataW-1:0] data);
      case (idx)
        pdfc_pkg::RegPropGain:  prop_gain = longint'(data[23:0]);
        pdfc_pkg::RegDerivGain: deriv_gain = longint'(data[23:0]);
        pdfc_pkg::RegApproach:  divisor = longint'(data[15:0]);
        pdfc_pkg::RegLimit:     force_limit = longint'(data[23:0]);
        default: ;
      endcase
    endfunction

    function longint clamp_err(longint v);
      if (v > ErrMax) return ErrMax;
      if (v < ErrMin) return ErrMin;
      return v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bit_w;
      root = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
        if (v >= root + bit_w) begin
          v = v - (root + bit_w);
          root = (root >> 1) + bit_w;
        end else begin
          root = root >> 1;
        end
        bit_w = bit_w >> 2;
      end
      return root;
    endfunction

    // Error, derivative and gain terms of one axis; advance its previous error.
    function longint axis_force(longint master, longint slave, int ax);
      longint div_eff, err, derr, t1, t2;
      div_eff = (divisor == 0) ? 1 : divisor;
      err = clamp_err(((master - slave) * 256) / div_eff);
      derr = clamp_err(err - prev_err[ax]);
      t1 = (prop_gain * err) >>> 24;
      t2 = (deriv_gain * derr) >>> 24;
      prev_err[ax] = err;
      return (t1 + t2) * 100;
    endfunction

    function void note_pos(pdfc_pkg::pos_req_t p);
      longint f[3];
      longint unsigned mag[3], sh[3], sq, sum, root, quo;
      logic lim;
      int unsigned k;
      pdfc_pkg::force_rsp_t r;
      f[0] = axis_force(longint'(p.master_x), longint'(p.slave_x), 0);
      f[1] = axis_force(longint'(p.master_y), longint'(p.slave_y), 1);
      f[2] = axis_force(longint'(p.master_z), longint'(p.slave_z), 2);
      lim = 1'b0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = (f[i] < 0) ? longint'(-f[i]) : f[i];
        if (mag[i] > force_limit) lim = 1'b1;
      end
      if (!lim) begin
        sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        if (sq > force_limit * force_limit) lim = 1'b1;
      end
      if (lim) begin
        // Scale the vector down so the squares fit, then divide by its length.
        k = 0;
        while (((mag[0] >> k) | (mag[1] >> k) | (mag[2] >> k)) >= (64'd1 << 30)) k++;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
          sh[i] = mag[i] >> k;
          sum = sum + sh[i] * sh[i];
        end
        root = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
          quo = (root == 0) ? 0 : (sh[i] << 16) / root;
          f[i] = (f[i] < 0) ? -longint'(quo) : longint'(quo);
        end
      end
      r.force_x = f[0][31:0];
      r.force_y = f[1][31:0];
      r.force_z = f[2][31:0];
      r.limited = lim;
      owed_forces.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_force(pdfc_pkg::force_rsp_t got);
      pdfc_pkg::force_rsp_t want;
      if (owed_forces.size() == 0) begin
        report($sformatf("unexpected force %h", got));
        return;
      end
      want = owed_forces.pop_front();
      if (got.force_x !== want.force_x)
        report($sformatf("force_x got %h want %h", got.force_x, want.force_x));
      if (got.force_y !== want.force_y)
        report($sformatf("force_y got %h want %h", got.force_y, want.force_y));
      if (got.force_z !== want.force_z)
        report($sformatf("force_z got %h want %h", got.force_z, want.force_z));
      if (got.limited !== want.limited)
        report($sformatf("limited got %b want %b", got.limited, want.limited));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic calm = 1'b0;
  int unsigned cycles = 0;
  force_scoreboard sb = new();

  pdfc_cfg_if   cfg_ch();
  pdfc_pos_if   pos_ch();
  pdfc_force_if frc_ch();

  pd_force_controller_3axis i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_ch.sink),
    .pos    (pos_ch.sink),
    .frc    (frc_ch.source)
  );

  always #4 clk_i = ~clk_i;

  // Count cycles and give up on a hung block.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Stall the force channel at random outside the calm window; check every accepted force.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (frc_ch.valid && frc_ch.ready) sb.check_force(frc_ch.data);
      frc_ch.ready <= calm || ($urandom_range(99) >= 13);
    end
  end

  function automatic logic idle_now();
    return !calm && ($urandom_range(99) < 13);
  endfunction

  task automatic write_reg(logic [pdfc_pkg::CfgIdxW-1:0] idx,
                           logic [pdfc_pkg::CfgDataW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{idx: idx, data: data};
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.set_reg(idx, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold the request until accepted; valid stays high into the next request unless idling.
  task automatic send_pos(pdfc_pkg::pos_req_t p);
    if (idle_now()) begin
      pos_ch.valid <= 1'b0;
      do @(posedge clk_i); while (idle_now());
    end
    pos_ch.valid <= 1'b1;
    pos_ch.data <= p;
    do @(posedge clk_i); while (!pos_ch.ready);
    sb.note_pos(p);
  endtask

  task automatic drain();
    pos_ch.valid <= 1'b0;
    while (sb.owed_forces.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_all(logic [31:0] kp, logic [31:0] kd, logic [31:0] dv, logic [31:0] lim);
    write_reg(pdfc_pkg::RegPropGain, kp);
    write_reg(pdfc_pkg::RegDerivGain, kd);
    write_reg(pdfc_pkg::RegApproach, dv);
    write_reg(pdfc_pkg::RegLimit, lim);
  endtask

  // Mix near positions, full range positions and extremes.
  function automatic logic signed [31:0] near(logic signed [31:0] m);
    return m + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
  endfunction

  function automatic pdfc_pkg::pos_req_t random_pos();
    pdfc_pkg::pos_req_t p;
    int unsigned sel;
    logic signed [31:0] ext[4] = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1};
    sel = $urandom_range(9);
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (sel < 5) begin
      p.slave_x = near(p.master_x);
      p.slave_y = near(p.master_y);
      p.slave_z = near(p.master_z);
    end else if (sel < 6) begin
      p.master_x = ext[$urandom_range(3)];
      p.slave_z = ext[$urandom_range(3)];
      p.slave_y = p.master_y;
    end
    return p;
  endfunction

  initial begin
    pdfc_pkg::pos_req_t p;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    pos_ch.valid = 1'b0;
    pos_ch.data = '0;
    frc_ch.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks at reset settings: zero, extremes, equal and near positions.
    send_pos('0);
    send_pos('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
               32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000});
    send_pos('{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
               32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff});
    send_pos('{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 0});
    send_pos('{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 0});
    send_pos('{-1, -1, -1, -1, -1, -1});
    send_pos('{0, 0, 32'sh0010_0000, 0, 0, 0});
    drain();

    // Zero divisor, full gains, zero limit: any nonzero force is limited and normalized.
    set_all(32'hff_ffff, 32'hff_ffff, 0, 0);
    send_pos('{32'sh7fff_ffff, 0, 0, 32'sh8000_0000, 0, 0});
    send_pos('{1, 0, 0, 0, 0, 0});
    send_pos('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
               32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff});
    send_pos('0);
    drain();

    // Zero gains, largest divisor and limit: forces pass through unlimited.
    set_all(0, 0, 32'hffff, 32'hff_ffff);
    send_pos('{32'sh7fff_ffff, 1, 2, 3, 4, 5});
    send_pos('0);
    drain();

    // Random phases; the third runs without any idling on either side.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_all(58982, 98304, 10000, 157286);
        1: set_all(1, 1, 1, 32'hff_ffff);
        2: set_all($urandom_range(32'hff_ffff), $urandom_range(32'hff_ffff), 0,
                   $urandom_range(32'hff_ffff));
        3: set_all(32'hff_ffff, 0, 32'hffff, 0);
        4: set_all($urandom_range(65536), $urandom_range(65536),
                   $urandom_range(1, 65535), $urandom_range(1 << 20));
        default: set_all($urandom, $urandom, $urandom, $urandom);
      endcase
      calm <= (ph == 2);
      for (int n = 0; n < 320; n++) begin
        p = random_pos();
        send_pos(p);
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
